### src/assert_macros.svh
// assertion macros used by the projection unit controller
// expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define VPTS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// antecedent in one cycle implies consequent in the next
`define VPTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### src/vpts_pkg.sv
// types and constants of the vertex projection unit
// used by the controller, the datapath and the top level
`default_nettype none

package vpts_pkg;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_POINT = 1'b1;

	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	localparam int SIZE_W    = 14;
	localparam int SCR_W     = 19;
	localparam int EYE_W     = 32;
	localparam int QUOT_W    = 34;
	localparam int W_MIN_Q24 = 1677;
	localparam int DIV_STEPS = 34;
	localparam int MAC_STEPS = 16;
	localparam int DRAIN     = 3;

	typedef enum logic [3:0] {
		ST_IDLE, ST_EYE, ST_EYE_WAIT, ST_CLIP, ST_CLIP_WAIT, ST_CHECK,
		ST_DIV_X, ST_MUL_X, ST_RND_X, ST_DIV_Y, ST_MUL_Y, ST_RND_Y, ST_DONE
	} state_t;

	typedef enum logic {PH_EYE, PH_CLIP} phase_t;
	typedef enum logic {AXIS_X, AXIS_Y} axis_t;

	typedef struct packed {
		logic       wr;
		logic       start;
		logic       mac_valid;
		phase_t     phase;
		logic [3:0] k;
		logic       div_init;
		axis_t      div_sel;
		logic       div_step;
		logic       div_first;
		logic       scale_mul;
		logic       round_store;
		axis_t      rnd_sel;
		logic       set_vis;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic reject;
		logic out_busy;
	} status_t;

endpackage

`default_nettype wire

### src/vpts_ram.sv
// generic single port ram with registered read
// no dependencies
`default_nettype none

module vpts_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

### src/vpts_ctrl.sv
// sequencer of the projection unit: mac steps, division, scaling, output
// depends on vpts_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module vpts_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              req_type,
	output logic                   in_ready,
	input  wire vpts_pkg::status_t stat,
	output vpts_pkg::cmd_t         cmd
);
	import vpts_pkg::*;

	state_t     state_q, state_d;
	logic [5:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = '0;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.k    = cnt_q[3:0];
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (req_type == REQ_POINT) begin
						cmd.start = 1'b1;
						state_d   = ST_EYE;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			ST_EYE, ST_CLIP: begin
				cmd.mac_valid = 1'b1;
				cmd.phase     = (state_q == ST_EYE) ? PH_EYE : PH_CLIP;
				if (cnt_q == 6'(MAC_STEPS - 1)) begin
					state_d = (state_q == ST_EYE) ? ST_EYE_WAIT : ST_CLIP_WAIT;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			ST_EYE_WAIT, ST_CLIP_WAIT: begin
				if (cnt_q == 6'(DRAIN - 1)) begin
					state_d = (state_q == ST_EYE_WAIT) ? ST_CLIP : ST_CHECK;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			ST_CHECK: begin
				cmd.set_vis = 1'b1;
				if (stat.reject) begin
					state_d = ST_DONE;
				end else begin
					cmd.div_init = 1'b1;
					cmd.div_sel  = AXIS_X;
					state_d      = ST_DIV_X;
				end
			end
			ST_DIV_X, ST_DIV_Y: begin
				cmd.div_step  = 1'b1;
				cmd.div_first = (cnt_q == 6'd0);
				if (cnt_q == 6'(DIV_STEPS - 1)) begin
					state_d = (state_q == ST_DIV_X) ? ST_MUL_X : ST_MUL_Y;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			ST_MUL_X: begin
				cmd.scale_mul = 1'b1;
				cmd.rnd_sel   = AXIS_X;
				state_d       = ST_RND_X;
			end
			ST_RND_X: begin
				cmd.round_store = 1'b1;
				cmd.rnd_sel     = AXIS_X;
				cmd.div_init    = 1'b1;
				cmd.div_sel     = AXIS_Y;
				state_d         = ST_DIV_Y;
			end
			ST_MUL_Y: begin
				cmd.scale_mul = 1'b1;
				cmd.rnd_sel   = AXIS_Y;
				state_d       = ST_RND_Y;
			end
			ST_RND_Y: begin
				cmd.round_store = 1'b1;
				cmd.rnd_sel     = AXIS_Y;
				state_d         = ST_DONE;
			end
			ST_DONE: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`VPTS_ASSERT(a_load_free, !(cmd.out_load && stat.out_busy))
	`VPTS_ASSERT_NEXT(a_start_eye, cmd.start, state_q == ST_EYE)
	`VPTS_ASSERT(a_one_unit, !(cmd.mac_valid && (cmd.div_step || cmd.div_init)))

endmodule

`default_nettype wire

### src/vpts_datapath.sv
// matrix store, shared multiplier and accumulator, divider, scaling, output register
// depends on vpts_pkg and vpts_ram
`default_nettype none

module vpts_datapath #(
	parameter int COEF_WIDTH  = 24,
	parameter int COORD_WIDTH = 20
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire vpts_pkg::cmd_t                 cmd,
	output vpts_pkg::status_t                   stat,
	input  wire logic [4:0]                     entry_index,
	input  wire logic signed [COEF_WIDTH-1:0]   entry_value,
	input  wire logic signed [COORD_WIDTH-1:0]  point_x,
	input  wire logic signed [COORD_WIDTH-1:0]  point_y,
	input  wire logic signed [COORD_WIDTH-1:0]  point_z,
	input  wire logic                           cfg_valid,
	input  wire logic                           cfg_index,
	input  wire logic [vpts_pkg::SIZE_W-1:0]    cfg_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                visible,
	output logic signed [vpts_pkg::SCR_W-1:0]   screen_x,
	output logic signed [vpts_pkg::SCR_W-1:0]   screen_y
);
	import vpts_pkg::*;

	localparam int PW   = COEF_WIDTH + EYE_W;
	localparam int ACCW = COEF_WIDTH + 27;
	localparam int MW   = ACCW + 6;
	localparam int SPW  = SIZE_W + QUOT_W;
	localparam int RW   = SPW + 4;

	logic [SIZE_W-1:0] width_q, height_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_W'(1920);
			height_q <= SIZE_W'(1080);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// coefficient address from step index, or from entry_index outside the mac steps
	logic [1:0] row, term;
	logic [4:0] addr;
	logic signed [COEF_WIDTH-1:0] rdata;
	assign row  = cmd.k[3:2];
	assign term = cmd.k[1:0];
	always_comb begin
		if (!cmd.mac_valid) begin
			addr = entry_index;
		end else if (cmd.phase == PH_CLIP) begin
			addr = {1'b1, term, row};
		end else if (term == 2'd0) begin
			addr = {1'b0, 2'b11, row};
		end else begin
			addr = {1'b0, term - 2'd1, row};
		end
	end

	vpts_ram #(.WIDTH(COEF_WIDTH), .DEPTH(32)) u_ram (
		.clk   (clk),
		.we    (cmd.wr),
		.addr  (addr),
		.wdata (entry_value),
		.rdata (rdata)
	);

	logic signed [EYE_W-1:0] p_q [3];
	logic signed [EYE_W-1:0] eye_q [4];
	logic signed [ACCW-1:0]  clip_q [4];
	logic signed [ACCW-1:0]  acc_q;
	logic                    ovf_q;

	logic         valid_s1, valid_s2;
	logic [3:0]   k_s1, k_s2;
	phase_t       phase_s1, phase_s2;
	logic signed [PW-1:0] prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.mac_valid;
			valid_s2 <= valid_s1;
		end
	end

	logic signed [EYE_W-1:0] b_sel;
	always_comb begin
		if (phase_s1 == PH_CLIP) begin
			b_sel = eye_q[k_s1[1:0]];
		end else if (k_s1[1:0] == 2'd0) begin
			b_sel = EYE_W'(256);
		end else begin
			b_sel = p_q[k_s1[1:0] - 2'd1];
		end
	end

	logic signed [ACCW-1:0] term_v, acc_n;
	logic                   sat_hi, sat_lo;
	localparam logic signed [ACCW-1:0] EMAX = {{(ACCW-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [ACCW-1:0] EMIN = {{(ACCW-31){1'b1}}, 31'b0};
	assign term_v = {{(ACCW-PW+8){prod_s2[PW-1]}}, prod_s2[PW-1:8]};
	assign acc_n  = ((k_s2[1:0] == 2'd0) ? '0 : acc_q) + term_v;
	assign sat_hi = acc_n > EMAX;
	assign sat_lo = acc_n < EMIN;

	// divider, scaling and rounding
	logic [ACCW:0]       r_q;
	logic [QUOT_W-1:0]   q_q;
	logic                neg_q;
	logic [SPW-1:0]      scl_s;
	logic signed [SCR_W-1:0] sx_q, sy_q;
	logic                vis_q;

	logic signed [ACCW:0] num;
	logic [ACCW:0]        den, cmp, rs;
	logic                 ge;
	assign num = (cmd.div_sel == AXIS_X) ? (ACCW+1)'(clip_q[0]) + (ACCW+1)'(clip_q[3])
	                                     : (ACCW+1)'(clip_q[1]) + (ACCW+1)'(clip_q[3]);
	assign den = {1'b0, clip_q[3]};
	assign cmp = cmd.div_first ? {den[ACCW-1:0], 1'b0} : den;
	assign ge  = r_q >= cmp;
	assign rs  = ge ? r_q - cmp : r_q;

	logic [RW-1:0]   rsum;
	logic [19:0]     smag;
	logic signed [SCR_W-1:0] sval;
	assign rsum = {1'b0, scl_s, 3'b000} + RW'(64'h8000_0000);
	always_comb begin
		smag = rsum[RW-1:32];
		if (smag > 20'd262144) begin
			smag = 20'd262144;
		end
		if (neg_q) begin
			sval = SCR_W'(-smag);
		end else if (smag > 20'd262143) begin
			sval = SCR_W'(20'd262143);
		end else begin
			sval = SCR_W'(smag);
		end
	end

	// rejection tests on clip coordinates
	logic [ACCW:0] mag0, mag1;
	logic [MW-1:0] lim, m20_0, m20_1;
	assign mag0  = clip_q[0][ACCW-1] ? -(ACCW+1)'(clip_q[0]) : (ACCW+1)'(clip_q[0]);
	assign mag1  = clip_q[1][ACCW-1] ? -(ACCW+1)'(clip_q[1]) : (ACCW+1)'(clip_q[1]);
	assign m20_0 = (MW'(mag0) << 4) + (MW'(mag0) << 2);
	assign m20_1 = (MW'(mag1) << 4) + (MW'(mag1) << 2);
	assign lim   = (MW'(den) << 4) + (MW'(den) << 2) + (MW'(den) << 1) + MW'(den);
	assign stat.reject = ovf_q || (clip_q[3] <= ACCW'(W_MIN_Q24)) || (m20_0 > lim)
	                     || (m20_1 > lim);
	assign stat.out_busy = out_valid && !out_ready;

	always_ff @(posedge clk) begin
		k_s1     <= cmd.k;
		phase_s1 <= cmd.phase;
		k_s2     <= k_s1;
		phase_s2 <= phase_s1;
		prod_s2  <= rdata * b_sel;
		if (cmd.start) begin
			p_q[0] <= EYE_W'(point_x);
			p_q[1] <= EYE_W'(point_y);
			p_q[2] <= EYE_W'(point_z);
			ovf_q  <= 1'b0;
		end
		if (valid_s2) begin
			acc_q <= acc_n;
			if (k_s2[1:0] == 2'd3) begin
				if (phase_s2 == PH_EYE) begin
					eye_q[k_s2[3:2]] <= sat_hi ? EYE_W'(EMAX) :
					                    sat_lo ? EYE_W'(EMIN) : EYE_W'(acc_n);
					if (sat_hi || sat_lo) begin
						ovf_q <= 1'b1;
					end
				end else begin
					clip_q[k_s2[3:2]] <= acc_n;
				end
			end
		end
		if (cmd.div_init) begin
			neg_q <= num[ACCW];
			r_q   <= num[ACCW] ? -num : num;
			q_q   <= '0;
		end else if (cmd.div_step) begin
			r_q <= cmd.div_first ? rs : {rs[ACCW-1:0], 1'b0};
			q_q <= {q_q[QUOT_W-2:0], ge};
		end
		if (cmd.scale_mul) begin
			scl_s <= ((cmd.rnd_sel == AXIS_X) ? SPW'(width_q) : SPW'(height_q)) * SPW'(q_q);
		end
		if (cmd.round_store) begin
			if (cmd.rnd_sel == AXIS_X) begin
				sx_q <= sval;
			end else begin
				sy_q <= sval;
			end
		end
		if (cmd.set_vis) begin
			vis_q <= !stat.reject;
		end
		if (cmd.out_load) begin
			visible  <= vis_q;
			screen_x <= vis_q ? sx_q : '0;
			screen_y <= vis_q ? sy_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

endmodule

`default_nettype wire

### src/vertex_project_to_screen_unit.sv
// top level of the vertex projection unit: controller and datapath
// depends on vpts_pkg, vpts_ctrl, vpts_datapath and vpts_ram
//
// input channel (in_valid/in_ready): req_type 0 writes coefficient entry_index
// (0-15 view, 16-31 projection, column-major) and gives no result;
// req_type 1 projects (point_x, point_y, point_z, 1) and gives one result.
// output channel (out_valid/out_ready) carries visible, screen_x, screen_y.
// config channel (cfg_valid/cfg_ready, always ready): index 0 screen width,
// index 1 screen height, to be written only while idle; the block does not
// enforce it. a point transaction runs 16 mac steps for the view matrix and
// 16 for the projection on one shared multiplier with a three stage pipe,
// then two 34 step restoring divisions and a scale multiply per axis before
// out_valid rises; a rejected point skips the divisions. one point is in work
// at a time; the result register lets the next transaction start while a
// result waits, and the sequencer holds its last step while the receiver
// stalls.
// reset clears control state and sets width 1920, height 1080; the matrix store
// is undefined until written.
`default_nettype none

module vertex_project_to_screen_unit #(
	parameter int COEF_WIDTH  = 24,
	parameter int COORD_WIDTH = 20
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           req_type,
	input  wire logic [4:0]                     entry_index,
	input  wire logic signed [COEF_WIDTH-1:0]   entry_value,
	input  wire logic signed [COORD_WIDTH-1:0]  point_x,
	input  wire logic signed [COORD_WIDTH-1:0]  point_y,
	input  wire logic signed [COORD_WIDTH-1:0]  point_z,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic                           cfg_index,
	input  wire logic [vpts_pkg::SIZE_W-1:0]    cfg_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                visible,
	output logic signed [vpts_pkg::SCR_W-1:0]   screen_x,
	output logic signed [vpts_pkg::SCR_W-1:0]   screen_y
);
	import vpts_pkg::*;

	cmd_t    cmd;
	status_t stat;

	assign cfg_ready = 1'b1;

	vpts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	vpts_datapath #(
		.COEF_WIDTH  (COEF_WIDTH),
		.COORD_WIDTH (COORD_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.visible     (visible),
		.screen_x    (screen_x),
		.screen_y    (screen_y)
	);

endmodule

`default_nettype wire

### tb/vpts_checker.sv
// result checker for the vertex projection unit: watches the three channels,
// predicts each point transaction and compares the results, field by field
// depends on vpts_pkg
`timescale 1ns / 100ps

module vpts_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic                         req_type,
	input  logic [4:0]                   entry_index,
	input  logic signed [23:0]           entry_value,
	input  logic signed [19:0]           point_x,
	input  logic signed [19:0]           point_y,
	input  logic signed [19:0]           point_z,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [vpts_pkg::SIZE_W-1:0]  cfg_data,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic                         visible,
	input  logic signed [vpts_pkg::SCR_W-1:0] screen_x,
	input  logic signed [vpts_pkg::SCR_W-1:0] screen_y,
	output int                           fail_count,
	output int                           pending_count
);
	import vpts_pkg::*;

	typedef struct packed {
		logic                    vis;
		logic signed [SCR_W-1:0] sx;
		logic signed [SCR_W-1:0] sy;
	} pixel_t;

	longint coef[32];
	longint unsigned width_px = 1920;
	longint unsigned height_px = 1080;
	pixel_t pixel_queue[$];

	function automatic longint scale_axis(longint c, longint w, longint unsigned size);
		longint num;
		bit neg;
		longint unsigned mag, q, r, s;
		longint v;
		num = c + w;
		neg = num < 0;
		mag = neg ? -num : num;
		q = mag / w;
		r = mag % w;
		for (int i = 0; i < 32; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= w) begin
				r = r - w;
				q = q | 64'd1;
			end
		end
		s = (8 * size * q + (64'd1 << 31)) >> 32;
		if (s > 262144)
			s = 262144;
		v = neg ? -longint'(s) : longint'(s);
		if (v > 262143)
			v = 262143;
		if (v < -262144)
			v = -262144;
		return v;
	endfunction

	function automatic pixel_t project_point(longint px, longint py, longint pz);
		longint pt[3];
		longint eye[4];
		longint clip[4];
		longint s, mag;
		bit ovf;
		pixel_t res;
		pt[0] = px;
		pt[1] = py;
		pt[2] = pz;
		ovf = 0;
		res = '0;
		for (int i = 0; i < 4; i++) begin
			s = coef[12 + i];
			for (int j = 0; j < 3; j++)
				s += (coef[j * 4 + i] * pt[j]) >>> 8;
			if (s > 64'sd2147483647) begin
				s = 64'sd2147483647;
				ovf = 1;
			end else if (s < -64'sd2147483648) begin
				s = -64'sd2147483648;
				ovf = 1;
			end
			eye[i] = s;
		end
		for (int i = 0; i < 4; i++) begin
			s = 0;
			for (int j = 0; j < 4; j++)
				s += (coef[16 + j * 4 + i] * eye[j]) >>> 8;
			clip[i] = s;
		end
		if (ovf || clip[3] <= W_MIN_Q24)
			return res;
		for (int i = 0; i < 2; i++) begin
			mag = clip[i] < 0 ? -clip[i] : clip[i];
			if (20 * mag > 23 * clip[3])
				return res;
		end
		res.vis = 1'b1;
		res.sx = SCR_W'(scale_axis(clip[0], clip[3], width_px));
		res.sy = SCR_W'(scale_axis(clip[1], clip[3], height_px));
		return res;
	endfunction

	initial begin
		fail_count = 0;
		pending_count = 0;
		for (int i = 0; i < 32; i++)
			coef[i] = 0;
	end

	always @(posedge clk) begin
		pixel_t want;
		pixel_t pred;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SCREEN_WIDTH)
					width_px = 64'(cfg_data);
				else
					height_px = 64'(cfg_data);
			end
			if (in_valid && in_ready) begin
				if (req_type == REQ_WRITE) begin
					coef[entry_index] = longint'(entry_value);
				end else begin
					pred = project_point(longint'(point_x), longint'(point_y),
						longint'(point_z));
					pixel_queue = {pixel_queue, pred};
				end
			end
			if (out_valid && out_ready) begin
				if (pixel_queue.size() == 0) begin
					$error("result transaction with no point waiting");
					fail_count++;
				end else begin
					want = pixel_queue.pop_front();
					if (visible !== want.vis) begin
						$error("visible: expected %0d, got %0d", want.vis, visible);
						fail_count++;
					end
					if (screen_x !== want.sx) begin
						$error("screen_x: expected %0d, got %0d", want.sx, screen_x);
						fail_count++;
					end
					if (screen_y !== want.sy) begin
						$error("screen_y: expected %0d, got %0d", want.sy, screen_y);
						fail_count++;
					end
				end
			end
		end
		pending_count = pixel_queue.size();
	end

endmodule

### tb/testbench.sv
// top of the vertex projection unit testbench: clock, reset, stimulus and verdict
// depends on vpts_pkg, vertex_project_to_screen_unit and vpts_checker
`timescale 1ns / 100ps

module testbench;
	import vpts_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE = 250;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic req_type = REQ_WRITE;
	logic [4:0] entry_index = '0;
	logic signed [23:0] entry_value = '0;
	logic signed [19:0] point_x = '0;
	logic signed [19:0] point_y = '0;
	logic signed [19:0] point_z = '0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic cfg_index = REG_SCREEN_WIDTH;
	logic [SIZE_W-1:0] cfg_data = '0;
	logic out_valid;
	logic out_ready = 0;
	logic visible;
	logic signed [SCR_W-1:0] screen_x, screen_y;
	int fail_count, pending_count;

	int burst_left = 0;
	int sent = 0;
	bit hold_req = 0;
	int idle_cycles = 0;

	vertex_project_to_screen_unit DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .entry_index(entry_index), .entry_value(entry_value),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .out_valid(out_valid), .out_ready(out_ready),
		.visible(visible), .screen_x(screen_x), .screen_y(screen_y)
	);

	vpts_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .entry_index(entry_index), .entry_value(entry_value),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .out_valid(out_valid), .out_ready(out_ready),
		.visible(visible), .screen_x(screen_x), .screen_y(screen_y),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// receiver stall pattern, plus one long hold-off
	initial begin
		int seg_left, mode;
		bit held;
		seg_left = 0;
		mode = 0;
		held = 0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1;
				out_ready <= 1'b0;
				repeat (700) @(posedge clk);
			end
			if (seg_left == 0) begin
				mode = $urandom_range(0, 3);
				seg_left = $urandom_range(10, 200);
			end
			seg_left--;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	task automatic send_item(logic kind, logic [4:0] idx, logic signed [23:0] val,
		logic signed [19:0] x, logic signed [19:0] y, logic signed [19:0] z);
		int gap;
		in_valid <= 1'b1;
		req_type <= kind;
		entry_index <= idx;
		entry_value <= val;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
		if (sent == 300)
			hold_req = 1;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic write_coef(logic [4:0] idx, logic signed [23:0] val);
		send_item(REQ_WRITE, idx, val, 20'($urandom), 20'($urandom), 20'($urandom));
	endtask

	task automatic send_point(logic signed [19:0] x, logic signed [19:0] y,
		logic signed [19:0] z);
		send_item(REQ_POINT, 5'($urandom), 24'($urandom), x, y, z);
	endtask

	// block idle before any register write
	task automatic set_screen(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		for (int i = 0; i < 2; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= (i == 0) ? REG_SCREEN_WIDTH : REG_SCREEN_HEIGHT;
			cfg_data <= (i == 0) ? w : h;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// identity view, identity projection with w scaled
	task automatic load_identity(logic signed [23:0] w_scale);
		for (int i = 0; i < 32; i++)
			write_coef(5'(i), (i == 31) ? w_scale :
				(i % 5 == ((i < 16) ? 0 : 1)) ? 24'sd65536 : 24'sd0);
	endtask

	// random view and projection that keep many points in view
	task automatic load_scene();
		logic signed [23:0] v;
		for (int i = 0; i < 32; i++) begin
			if (i < 12 && i % 4 == 3)
				v = '0;
			else if (i == 15)
				v = 24'sd65536;
			else if (i < 12)
				v = 24'($urandom_range(0, 131072) - 65536);
			else if (i < 15)
				v = 24'($urandom_range(0, 2097152) - 1048576);
			else if (i == 19 || i == 23)
				v = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 8192) - 4096) : '0;
			else if (i == 27)
				v = 24'($urandom_range(0, 131072) - 65536);
			else if (i == 31)
				v = 24'($urandom_range(0, 262144));
			else
				v = 24'($urandom_range(0, 262144) - 131072);
			write_coef(5'(i), v);
		end
	endtask

	initial begin
		logic [SIZE_W-1:0] sizes[6];
		int r;
		sizes = '{14'd1, 14'd8192, 14'd16383, 14'd0, 14'd640, 14'd1920};
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: margin edge, w threshold, overflow and extremes
		set_screen(14'd16383, 14'd1);
		load_identity(24'sd51200);
		send_point(20'sd230, 20'sd0, 20'sd0);
		send_point(-20'sd230, 20'sd0, 20'sd0);
		send_point(20'sd231, 20'sd0, 20'sd0);
		send_point(20'sd0, 20'sd230, 20'sd0);
		send_point(20'sd0, -20'sd231, 20'sd0);
		send_point(20'sd0, 20'sd0, 20'sd0);
		send_point(20'sd524287, 20'sd524287, 20'sd524287);
		send_point(-20'sd524288, -20'sd524288, -20'sd524288);
		write_coef(5'd0, 24'sd8388607);
		send_point(20'sd524287, 20'sd0, 20'sd0);
		write_coef(5'd0, -24'sd8388608);
		send_point(20'sd524287, 20'sd0, 20'sd0);
		send_point(-20'sd524288, 20'sd0, 20'sd0);
		write_coef(5'd0, 24'sd65536);
		write_coef(5'd31, 24'sd0);
		send_point(20'sd0, 20'sd0, 20'sd0);
		write_coef(5'd31, 24'sd6);
		send_point(20'sd0, 20'sd0, 20'sd0);
		write_coef(5'd31, 24'sd7);
		send_point(20'sd0, 20'sd0, 20'sd0);
		write_coef(5'd31, -24'sd65536);
		send_point(20'sd5, 20'sd5, 20'sd5);

		// random phases
		for (int ph = 0; ph < 8; ph++) begin
			if (ph < 6)
				set_screen(sizes[ph], sizes[5 - ph]);
			else
				set_screen(14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)));
			load_scene();
			for (int n = 0; n < 72; n++) begin
				r = $urandom_range(0, 99);
				if (r < 8)
					write_coef(5'($urandom), 24'($urandom));
				else if (r < 14)
					send_point(20'($urandom), 20'($urandom), 20'($urandom));
				else
					send_point(20'($urandom_range(0, 8192) - 4096),
						20'($urandom_range(0, 8192) - 4096),
						20'($urandom_range(0, 8192) - 4096));
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
